>>> hdl/rcm_pkg.sv
// Package for the rod-cutting profit core: field widths, piece table,
// reset prices and the shared types for the cell chain.
// No dependencies.
package rcm_pkg;

    localparam int LEN_W          = 13;
    localparam int VALUE_W        = 20;
    localparam int PRICE_W        = 8;
    localparam int WINDOW         = 16;
    localparam int NUM_PIECES     = 8;
    localparam int MAX_LENGTH_DEF = 4096;
    localparam int PIECE_IDX_W    = $clog2(NUM_PIECES);
    localparam int PADDR_W        = PIECE_IDX_W + 2;
    localparam int S_TDATA_W      = ((LEN_W + 7) / 8) * 8;
    localparam int M_TDATA_W      = ((VALUE_W + 7) / 8) * 8;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    localparam int PIECE_LEN [NUM_PIECES] = '{1, 2, 4, 6, 8, 10, 12, 16};

    localparam logic [PRICE_W-1:0] PRICE_RESET [NUM_PIECES] =
        '{8'd1, 8'd5, 8'd9, 8'd17, 8'd20, 8'd30, 8'd36, 8'd48};

    // One cell of the chain: the best value at one length, and whether that
    // length has been worked out for the current transaction.
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } cell_data_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

    typedef logic [PRICE_W-1:0] price_t;

endpackage

>>> hdl/rcm_cell.sv
// One cell of the best-value chain: holds a value and hands it to the next
// cell on every shift. Depends on rcm_pkg.
module rcm_cell #(
    parameter bit INIT_VALID = 1'b0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rcm_pkg::cell_ctrl_t ctrl,
    input  rcm_pkg::cell_data_t prev,
    output rcm_pkg::cell_data_t data
);
    import rcm_pkg::*;

    logic               valid_reg;
    logic [VALUE_W-1:0] value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= INIT_VALID;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= INIT_VALID;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= prev.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            value_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            value_reg <= prev.value;
        end
    end

    assign data.valid = valid_reg;
    assign data.value = value_reg;

endmodule

>>> hdl/rcm_best.sv
// Candidate evaluation for one table step: price plus the tapped cell value
// for each piece that fits, saturated, then the maximum. Depends on rcm_pkg.
module rcm_best (
    input  rcm_pkg::cell_data_t                 cells [rcm_pkg::WINDOW],
    input  rcm_pkg::price_t                     prices [rcm_pkg::NUM_PIECES],
    output logic [rcm_pkg::VALUE_W-1:0]         best
);
    import rcm_pkg::*;

    logic [VALUE_W-1:0] cand [NUM_PIECES];

    // A piece fits exactly when the cell at its distance holds a real length.
    always_comb
    begin
        logic [VALUE_W:0] sum;
        for (int k = 0; k < NUM_PIECES; k++)
        begin
            sum = {1'b0, cells[PIECE_LEN[k] - 1].value}
                + {{(VALUE_W + 1 - PRICE_W){1'b0}}, prices[k]};
            if (!cells[PIECE_LEN[k] - 1].valid)
            begin
                cand[k] = '0;
            end
            else if (sum[VALUE_W])
            begin
                cand[k] = VALUE_MAX;
            end
            else
            begin
                cand[k] = sum[VALUE_W-1:0];
            end
        end
    end

    always_comb
    begin
        logic [VALUE_W-1:0] m;
        m = '0;
        for (int k = 0; k < NUM_PIECES; k++)
        begin
            if (cand[k] > m)
            begin
                m = cand[k];
            end
        end
        best = m;
    end

endmodule

>>> hdl/rod_cut_max_profit_core.sv
// Rod-cutting profit core: a chain of 16 cells holds the latest best values.
// One table length is worked out per cycle, set by the single step through the
// cell chain; a new rod length is accepted only when idle, after the result of
// the last one has been taken into the output register.
// Reset (rst_n, asynchronous, active low) restores the reset prices and idles.
module rod_cut_max_profit_core #(
    parameter int MAX_LENGTH = rcm_pkg::MAX_LENGTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // s_tdata: rod_length [12:0], zero fill above
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rcm_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: max_profit [19:0], zero fill above
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rcm_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rcm_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rcm_pkg::*;

    localparam int CNT_W = $clog2(MAX_LENGTH + 1);
    localparam int TGT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                   state_reg, state_next;
    logic [TGT_W-1:0]       len_reg, len_next;
    logic [TGT_W-1:0]       target_reg, target_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]     out_value_reg, out_value_next;
    price_t                 price_reg [NUM_PIECES];

    logic [PIECE_IDX_W-1:0] cfg_idx;
    logic [TGT_W-1:0]       req_ext;
    logic                   s_fire;
    logic                   done;
    logic [VALUE_W-1:0]     step_best;
    cell_ctrl_t             cell_ctrl;
    cell_data_t             cells [WINDOW];
    cell_data_t             chain_in [WINDOW];

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign prdata  = {{(32 - PRICE_W){1'b0}}, price_reg[cfg_idx]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_PIECES; k++)
            begin
                price_reg[k] <= PRICE_RESET[k];
            end
        end
        else if (psel && penable && pwrite && pready)
        begin
            price_reg[cfg_idx] <= pwdata[PRICE_W-1:0];
        end
    end

    // ---------------- sequencer ----------------
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign req_ext  = TGT_W'(s_tdata[LEN_W-1:0]);
    assign done     = (len_reg == target_reg);

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        target_next    = target_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        cell_ctrl      = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    cell_ctrl.clear = 1'b1;
                    len_next        = '0;
                    if (req_ext > TGT_W'(MAX_LENGTH))
                    begin
                        target_next = TGT_W'(MAX_LENGTH);
                    end
                    else
                    begin
                        target_next = req_ext;
                    end
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!done)
                begin
                    cell_ctrl.shift = 1'b1;
                    len_next        = len_reg + 1'b1;
                end
                else if (!out_valid_reg || m_tready)
                begin
                    // The head cell holds the value at the target length.
                    out_valid_next = 1'b1;
                    out_value_next = cells[0].value;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            target_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            target_reg    <= target_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - VALUE_W){1'b0}}, out_value_reg};

    // ---------------- cell chain ----------------
    rcm_best u_best (
        .cells  (cells),
        .prices (price_reg),
        .best   (step_best)
    );

    assign chain_in[0].valid = 1'b1;
    assign chain_in[0].value = step_best;

    // Cell j holds the best value at the current length minus j; after a clear
    // only the head cell is valid, standing for length zero.
    for (genvar j = 0; j < WINDOW; j++)
    begin : g_cell
        if (j > 0)
        begin : g_link
            assign chain_in[j] = cells[j-1];
        end
        rcm_cell #(
            .INIT_VALID (j == 0)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (cell_ctrl),
            .prev  (chain_in[j]),
            .data  (cells[j])
        );
    end

endmodule
